### rtl/label_bounding_box_table_defines.svh
// Assertion macros for the label bounding box table.
// Taken in by the top level; depends on nothing else.
`ifndef LABEL_BOUNDING_BOX_TABLE_DEFINES_SVH
`define LABEL_BOUNDING_BOX_TABLE_DEFINES_SVH

// same-cycle implication
`define LBT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lbt: same-cycle check failed");

// next-cycle implication
`define LBT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lbt: next-cycle check failed");

`endif

### rtl/lbt_pkg.sv
// Shared types and constants of the label bounding box table.
// Used by every module of the block; depends on nothing.
package lbt_pkg;

    localparam int LABEL_W     = 16;
    localparam int POS_OUT_W   = 12;
    localparam int COUNT_W     = 24;
    localparam int COLS_CFG_W  = 13;
    localparam int EPOCH_W     = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TUSER_W = 3;
    localparam int OUT_TDATA_W = 4 * POS_OUT_W + COUNT_W;

    localparam logic [COUNT_W-1:0]    COUNT_MAX         = 24'hFFFFFF;
    localparam logic [COLS_CFG_W-1:0] RASTER_COLS_RESET = 13'd1024;
    localparam logic [LABEL_W-1:0]    NO_DATA_RESET     = 16'hD8F1; // -9999
    localparam logic [EPOCH_W-1:0]    EPOCH_FIRST       = 8'd1;
    localparam logic [EPOCH_W-1:0]    EPOCH_LAST        = 8'hFF;

    typedef enum logic [1:0] {
        REQ_PIXEL = 2'd0,
        REQ_READ  = 2'd1,
        REQ_FRAME = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_ABSENT = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RASTER_COLS = 1'd0,
        CFG_NO_DATA     = 1'd1
    } cfg_reg_t;

    typedef struct packed {
        logic advance;
        logic clear;
    } pos_ctrl_t;

endpackage

### rtl/lbt_entry_ram.sv
// Single-port-write, single-port-read entry memory with registered read.
// Read data bypasses a write to the same address in the same cycle. Uses lbt_pkg.
module lbt_entry_ram
    import lbt_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 80
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/lbt_update.sv
// Entry merge: tag check, box widening and saturating count for one entry word.
// Also unpacks the stored box for the result beat. Uses lbt_pkg.
module lbt_update
    import lbt_pkg::*;
#(
    parameter int XW = 12,
    parameter int YW = 12,
    parameter int DW = EPOCH_W + 2 * XW + 2 * YW + COUNT_W
) (
    input  logic [DW-1:0]        old_word,
    input  logic [EPOCH_W-1:0]   epoch,
    input  logic [XW-1:0]        col,
    input  logic [YW-1:0]        row,
    output logic                 present,
    output logic [DW-1:0]        new_word,
    output logic [POS_OUT_W-1:0] x_min_out,
    output logic [POS_OUT_W-1:0] x_max_out,
    output logic [POS_OUT_W-1:0] y_min_out,
    output logic [POS_OUT_W-1:0] y_max_out,
    output logic [COUNT_W-1:0]   count_out
);

    // word layout from bit 0: count, y_max, y_min, x_max, x_min, tag
    localparam int YMAX_LO = COUNT_W;
    localparam int YMIN_LO = YMAX_LO + YW;
    localparam int XMAX_LO = YMIN_LO + YW;
    localparam int XMIN_LO = XMAX_LO + XW;
    localparam int TAG_LO  = XMIN_LO + XW;

    logic [EPOCH_W-1:0] old_tag;
    logic [XW-1:0]      old_x_min, old_x_max, new_x_min, new_x_max;
    logic [YW-1:0]      old_y_min, old_y_max, new_y_min, new_y_max;
    logic [COUNT_W-1:0] old_count, new_count;

    assign old_tag   = old_word[TAG_LO +: EPOCH_W];
    assign old_x_min = old_word[XMIN_LO +: XW];
    assign old_x_max = old_word[XMAX_LO +: XW];
    assign old_y_min = old_word[YMIN_LO +: YW];
    assign old_y_max = old_word[YMAX_LO +: YW];
    assign old_count = old_word[COUNT_W-1:0];

    // stale tags from earlier frames read as absent
    assign present = (old_tag == epoch);

    always_comb begin
        if (!present) begin
            new_x_min = col;
            new_x_max = col;
            new_y_min = row;
            new_y_max = row;
            new_count = COUNT_W'(1);
        end else begin
            new_x_min = (col < old_x_min) ? col : old_x_min;
            new_x_max = (col > old_x_max) ? col : old_x_max;
            new_y_min = (row < old_y_min) ? row : old_y_min;
            new_y_max = (row > old_y_max) ? row : old_y_max;
            new_count = (old_count == COUNT_MAX) ? old_count : old_count + COUNT_W'(1);
        end
    end

    assign new_word = {epoch, new_x_min, new_x_max, new_y_min, new_y_max, new_count};

    // zero-extend or truncate positions to the result field width
    logic [XW+POS_OUT_W-1:0] x_min_ext, x_max_ext;
    logic [YW+POS_OUT_W-1:0] y_min_ext, y_max_ext;

    assign x_min_ext = {{POS_OUT_W{1'b0}}, old_x_min};
    assign x_max_ext = {{POS_OUT_W{1'b0}}, old_x_max};
    assign y_min_ext = {{POS_OUT_W{1'b0}}, old_y_min};
    assign y_max_ext = {{POS_OUT_W{1'b0}}, old_y_max};

    assign x_min_out = x_min_ext[POS_OUT_W-1:0];
    assign x_max_out = x_max_ext[POS_OUT_W-1:0];
    assign y_min_out = y_min_ext[POS_OUT_W-1:0];
    assign y_max_out = y_max_ext[POS_OUT_W-1:0];
    assign count_out = old_count;

endmodule

### rtl/lbt_position.sv
// Raster position counters: column wraps at the clamped row width, row saturates.
// Uses lbt_pkg.
module lbt_position
    import lbt_pkg::*;
#(
    parameter int MAX_COLS = 4096,
    parameter int MAX_ROWS = 4096,
    parameter int XW       = 12,
    parameter int YW       = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pos_ctrl_t             ctrl,
    input  logic [COLS_CFG_W-1:0] raster_cols,
    output logic [XW-1:0]         col,
    output logic [YW-1:0]         row
);

    localparam int EW = (XW + 1 > COLS_CFG_W) ? XW + 1 : COLS_CFG_W;

    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;
    logic [EW-1:0] cols_ext, eff_cols, col_inc;
    logic          wrap;

    assign cols_ext = EW'(raster_cols);

    always_comb begin
        priority if (raster_cols == '0) begin
            eff_cols = EW'(1);
        end else if (cols_ext > EW'(MAX_COLS)) begin
            eff_cols = EW'(MAX_COLS);
        end else begin
            eff_cols = cols_ext;
        end
    end

    assign col_inc = EW'(col_reg) + EW'(1);
    assign wrap    = (col_inc >= eff_cols);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (ctrl.clear) begin
            col_next = '0;
            row_next = '0;
        end else if (ctrl.advance) begin
            if (wrap) begin
                col_next = '0;
                if (row_reg < YW'(MAX_ROWS - 1)) begin
                    row_next = row_reg + YW'(1);
                end
            end else begin
                col_next = col_inc[XW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col = col_reg;
    assign row = row_reg;

endmodule

### rtl/label_bounding_box_table.sv
// Label bounding box table: per-label box and pixel count over a label raster.
// Uses lbt_pkg, lbt_entry_ram, lbt_update, lbt_position and the assertion header.
//
// Usage:
//   s_* carries requests: s_tuser = req_type (pixel, read, new frame), s_tdata =
//   label_value. m_* returns one result beat per request. cfg_* writes the
//   row width (index 0) and the nodata label (index 1); write only while idle.
//   Pipeline: an accepted request beat is registered in stage 1 while the RAM
//   reads its entry, then in the result register that drives m_tvalid.
//   Throughput: one request per cycle while s_tready is high. Each beat
//   reads its entry from the entry RAM on acceptance and writes it back
//   as it leaves stage 1; the RAM read bypasses that write, so back-to-back
//   hits on one label need no bubble. Frames are tracked with an 8-bit epoch
//   tag per entry; a new-frame request bumps the tag. Every 255th new frame,
//   and after reset, a clearing pass rewrites all tags; s_tready is low during it.
//   A stalled m_tready holds the result register; one more request is taken
//   into the RAM read stage, then s_tready drops until the result is taken.
`include "label_bounding_box_table_defines.svh"

module label_bounding_box_table
    import lbt_pkg::*;
#(
    parameter int LABELS   = 1024,
    parameter int MAX_COLS = 4096,
    parameter int MAX_ROWS = 4096
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [LABEL_W-1:0]     cfg_data,
    // request channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [LABEL_W-1:0]     s_tdata,   // [15:0] label_value
    input  logic [IN_TUSER_W-1:0]  s_tuser,   // [1:0] req_type
    // result channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // box_x_min, box_x_max, box_y_min,
                                              // box_y_max, cell_count
    output logic [OUT_TUSER_W-1:0] m_tuser    // [1:0] status, [2] entry_present
);

    localparam int AW = $clog2(LABELS);
    localparam int XW = $clog2(MAX_COLS);
    localparam int YW = $clog2(MAX_ROWS);
    localparam int DW = EPOCH_W + 2 * XW + 2 * YW + COUNT_W;

    // configuration
    logic [COLS_CFG_W-1:0] raster_cols_reg;
    logic [LABEL_W-1:0]    no_data_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raster_cols_reg <= RASTER_COLS_RESET;
            no_data_reg     <= NO_DATA_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RASTER_COLS: raster_cols_reg <= cfg_data[COLS_CFG_W-1:0];
                CFG_NO_DATA:     no_data_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake and pipeline control
    logic                   s1_valid_reg;
    logic [IN_TUSER_W-1:0]  s1_req_reg;
    logic [LABEL_W-1:0]     s1_label_reg;
    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TUSER_W-1:0] m_tuser_reg;
    logic                   sweep_reg;
    logic [AW-1:0]          sweep_addr_reg;
    logic [EPOCH_W-1:0]     epoch_reg;

    logic out_free, s1_fire, s_accept, frame_hit, wrap_hold;

    assign out_free  = !m_valid_reg || m_tready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign frame_hit = (s1_req_reg == REQ_FRAME);
    // a wrapping frame must clear the tags before any later read
    assign wrap_hold = s1_valid_reg && frame_hit && (epoch_reg == EPOCH_LAST);
    assign s_tready  = !sweep_reg && !wrap_hold && (!s1_valid_reg || out_free);
    assign s_accept  = s_tvalid && s_tready;

    // label to table index
    logic [AW+LABEL_W-1:0] s_lab_ext, s1_lab_ext;
    logic [AW-1:0]         s_idx, s1_idx;
    logic                  s1_in_range;

    assign s_lab_ext   = {{AW{1'b0}}, s_tdata};
    assign s1_lab_ext  = {{AW{1'b0}}, s1_label_reg};
    assign s_idx       = s_lab_ext[AW-1:0];
    assign s1_idx      = s1_lab_ext[AW-1:0];
    assign s1_in_range = !s1_label_reg[LABEL_W-1] &&
                         (s1_lab_ext < (AW+LABEL_W)'(LABELS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_req_reg   <= s_tuser;
            s1_label_reg <= s_tdata;
        end
    end

    // entry memory and merge
    logic [DW-1:0]        rd_word, new_word, wr_word;
    logic [AW-1:0]        wr_addr;
    logic                 wr_en;
    logic [XW-1:0]        col;
    logic [YW-1:0]        row;
    logic                 present;
    logic [POS_OUT_W-1:0] x_min, x_max, y_min, y_max;
    logic [COUNT_W-1:0]   count;

    lbt_entry_ram #(
        .DEPTH (LABELS),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_en   (s_accept),
        .rd_addr (s_idx),
        .rd_data (rd_word)
    );

    lbt_update #(
        .XW (XW),
        .YW (YW),
        .DW (DW)
    ) u_update (
        .old_word  (rd_word),
        .epoch     (epoch_reg),
        .col       (col),
        .row       (row),
        .present   (present),
        .new_word  (new_word),
        .x_min_out (x_min),
        .x_max_out (x_max),
        .y_min_out (y_min),
        .y_max_out (y_max),
        .count_out (count)
    );

    // stage 1 decode
    status_t   st;
    logic      read_hit, pix_wr, advance;
    pos_ctrl_t pos_ctrl;

    always_comb begin
        st       = ST_DONE;
        read_hit = 1'b0;
        pix_wr   = 1'b0;
        advance  = 1'b0;
        unique case (s1_req_reg)
            REQ_PIXEL: begin
                advance = 1'b1;
                if (s1_label_reg != no_data_reg) begin
                    if (!s1_in_range) begin
                        st = ST_RANGE;
                    end else begin
                        pix_wr = 1'b1;
                    end
                end
            end
            REQ_READ: begin
                priority if (!s1_in_range) begin
                    st = ST_RANGE;
                end else if (!present) begin
                    st = ST_ABSENT;
                end else begin
                    read_hit = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign pos_ctrl.advance = s1_fire && advance;
    assign pos_ctrl.clear   = s1_fire && frame_hit;

    lbt_position #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .XW       (XW),
        .YW       (YW)
    ) u_position (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (pos_ctrl),
        .raster_cols (raster_cols_reg),
        .col         (col),
        .row         (row)
    );

    assign wr_en   = sweep_reg || (s1_fire && pix_wr);
    assign wr_addr = sweep_reg ? sweep_addr_reg : s1_idx;
    assign wr_word = sweep_reg ? '0 : new_word;

    // epoch tags and clearing pass; tag zero never matches a live epoch
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
            epoch_reg      <= EPOCH_FIRST;
        end else begin
            if (sweep_reg) begin
                sweep_addr_reg <= sweep_addr_reg + AW'(1);
                if (sweep_addr_reg == AW'(LABELS - 1)) begin
                    sweep_reg <= 1'b0;
                end
            end
            if (s1_fire && frame_hit) begin
                if (epoch_reg == EPOCH_LAST) begin
                    epoch_reg      <= EPOCH_FIRST;
                    sweep_reg      <= 1'b1;
                    sweep_addr_reg <= '0;
                end else begin
                    epoch_reg <= epoch_reg + EPOCH_W'(1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_tuser_reg <= {read_hit, st};
            m_tdata_reg <= read_hit ? {count, y_max, y_min, x_max, x_min} : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    `LBT_ASSERT_IMP(a_sweep_pipe_empty, aclk, aresetn, sweep_reg, !s1_valid_reg)
    `LBT_ASSERT_NXT(a_wrap_starts_sweep, aclk, aresetn,
                    s1_fire && frame_hit && (epoch_reg == EPOCH_LAST),
                    sweep_reg && (epoch_reg == EPOCH_FIRST))
    `LBT_ASSERT_IMP(a_epoch_live, aclk, aresetn, s1_valid_reg, epoch_reg != '0)

endmodule

### tb/label_bounding_box_table_checker.sv
// Result checker for the label bounding box table: watches the config, request and
// result channels, keeps its own copy of the table and compares every result beat.
// Depends on lbt_pkg for field widths and codes.
`timescale 1ns / 1ps

module label_bounding_box_table_checker
    import lbt_pkg::*;
#(
    parameter int LABELS   = 1024,
    parameter int MAX_COLS = 4096,
    parameter int MAX_ROWS = 4096
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [LABEL_W-1:0]     cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [LABEL_W-1:0]     s_tdata,   // [15:0] label_value
    input  logic [IN_TUSER_W-1:0]  s_tuser,   // [1:0] req_type
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // x_min, x_max, y_min, y_max, cell_count
    input  logic [OUT_TUSER_W-1:0] m_tuser,   // [1:0] status, [2] entry_present
    output int                     mismatches,
    output int                     results_due,
    output int                     results_seen
);

    typedef struct packed {
        status_t              status;
        logic                 present;
        logic [POS_OUT_W-1:0] x_min;
        logic [POS_OUT_W-1:0] x_max;
        logic [POS_OUT_W-1:0] y_min;
        logic [POS_OUT_W-1:0] y_max;
        logic [COUNT_W-1:0]   count;
    } box_result_t;

    logic                  entry_seen [LABELS];
    logic [POS_OUT_W-1:0]  x_lo [LABELS];
    logic [POS_OUT_W-1:0]  x_hi [LABELS];
    logic [POS_OUT_W-1:0]  y_lo [LABELS];
    logic [POS_OUT_W-1:0]  y_hi [LABELS];
    logic [COUNT_W-1:0]    hits [LABELS];
    int                    col_now;
    int                    row_now;
    logic [COLS_CFG_W-1:0] cols_cfg;
    logic [LABEL_W-1:0]    nodata_cfg;
    box_result_t           box_results_due [$];
    int                    bad_beats;
    int                    good_beats;

    function automatic int row_width();
        if (cols_cfg == '0) return 1;
        if (int'(cols_cfg) > MAX_COLS) return MAX_COLS;
        return int'(cols_cfg);
    endfunction

    // Applies one request to the shadow table and returns the result it should give.
    function automatic box_result_t predict_box_result(input logic [1:0] req,
                                                       input logic [LABEL_W-1:0] lab);
        box_result_t r;
        int          idx;
        logic        in_table;
        r = '0;
        idx = int'(lab);
        in_table = (lab[LABEL_W-1] == 1'b0) && (idx < LABELS);
        if (req == REQ_PIXEL) begin
            if (lab != nodata_cfg) begin
                if (!in_table) begin
                    r.status = ST_RANGE;
                end else if (!entry_seen[idx]) begin
                    entry_seen[idx] = 1'b1;
                    x_lo[idx] = POS_OUT_W'(col_now);
                    x_hi[idx] = POS_OUT_W'(col_now);
                    y_lo[idx] = POS_OUT_W'(row_now);
                    y_hi[idx] = POS_OUT_W'(row_now);
                    hits[idx] = COUNT_W'(1);
                end else begin
                    if (POS_OUT_W'(col_now) < x_lo[idx]) x_lo[idx] = POS_OUT_W'(col_now);
                    if (POS_OUT_W'(col_now) > x_hi[idx]) x_hi[idx] = POS_OUT_W'(col_now);
                    if (POS_OUT_W'(row_now) < y_lo[idx]) y_lo[idx] = POS_OUT_W'(row_now);
                    if (POS_OUT_W'(row_now) > y_hi[idx]) y_hi[idx] = POS_OUT_W'(row_now);
                    if (hits[idx] != COUNT_MAX) hits[idx] = hits[idx] + 1'b1;
                end
            end
            // nodata and out-of-range pixels still move the position
            col_now++;
            if (col_now >= row_width()) begin
                col_now = 0;
                if (row_now < MAX_ROWS - 1) row_now++;
            end
        end else if (req == REQ_READ) begin
            if (!in_table) begin
                r.status = ST_RANGE;
            end else if (!entry_seen[idx]) begin
                r.status = ST_ABSENT;
            end else begin
                r.present = 1'b1;
                r.x_min   = x_lo[idx];
                r.x_max   = x_hi[idx];
                r.y_min   = y_lo[idx];
                r.y_max   = y_hi[idx];
                r.count   = hits[idx];
            end
        end else if (req == REQ_FRAME) begin
            foreach (entry_seen[i]) entry_seen[i] = 1'b0;
            col_now = 0;
            row_now = 0;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        box_result_t want;
        box_result_t got;
        box_result_t due;
        if (!aresetn) begin
            foreach (entry_seen[i]) entry_seen[i] = 1'b0;
            col_now    = 0;
            row_now    = 0;
            cols_cfg   = RASTER_COLS_RESET;
            nodata_cfg = NO_DATA_RESET;
            box_results_due.delete();
            bad_beats  = 0;
            good_beats = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_RASTER_COLS) cols_cfg = cfg_data[COLS_CFG_W-1:0];
                else nodata_cfg = cfg_data;
            end
            // a result never leaves in the cycle its request is taken, so pop before push
            if (m_tvalid && m_tready) begin
                got.status  = status_t'(m_tuser[1:0]);
                got.present = m_tuser[2];
                got.x_min   = m_tdata[0*POS_OUT_W +: POS_OUT_W];
                got.x_max   = m_tdata[1*POS_OUT_W +: POS_OUT_W];
                got.y_min   = m_tdata[2*POS_OUT_W +: POS_OUT_W];
                got.y_max   = m_tdata[3*POS_OUT_W +: POS_OUT_W];
                got.count   = m_tdata[4*POS_OUT_W +: COUNT_W];
                if (box_results_due.size() == 0) begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("[%0t] unexpected result beat: status %0d present %0b",
                                 $realtime, got.status, got.present);
                end else begin
                    want = box_results_due.pop_front();
                    good_beats++;
                    if (got.status !== want.status || got.present !== want.present ||
                        got.x_min !== want.x_min || got.x_max !== want.x_max ||
                        got.y_min !== want.y_min || got.y_max !== want.y_max ||
                        got.count !== want.count) begin
                        bad_beats++;
                        if (bad_beats <= 10) begin
                            $display("[%0t] result %0d mismatch (status pres x0 x1 y0 y1 cnt)",
                                     $realtime, good_beats);
                            $display("    expected %0d %0b %0d %0d %0d %0d %0d", want.status,
                                     want.present, want.x_min, want.x_max, want.y_min,
                                     want.y_max, want.count);
                            $display("    actual   %0d %0b %0d %0d %0d %0d %0d", got.status,
                                     got.present, got.x_min, got.x_max, got.y_min,
                                     got.y_max, got.count);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                due = predict_box_result(s_tuser, s_tdata);
                box_results_due = {box_results_due, due};
            end
        end
        mismatches   <= bad_beats;
        results_due  <= box_results_due.size();
        results_seen <= good_beats;
    end

endmodule

### tb/label_bounding_box_table_tb.sv
// Top of the label bounding box table testbench: clock, reset, request and config
// stimulus, result back-pressure and the verdict.
// Depends on lbt_pkg, the block itself and label_bounding_box_table_checker.
`timescale 1ns / 1ps

module label_bounding_box_table_tb;
    import lbt_pkg::*;

    localparam int         LABELS      = 1024;
    localparam int         MAX_COLS    = 4096;
    localparam int         MAX_ROWS    = 4096;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         LABEL_POOL  = 16;
    localparam int         DRAIN_WAIT  = 8;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_reg_t               cfg_index = CFG_RASTER_COLS;
    logic [LABEL_W-1:0]     cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [LABEL_W-1:0]     s_tdata   = '0;
    logic [IN_TUSER_W-1:0]  s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b1;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;

    int                     mismatches;
    int                     results_due;
    int                     results_seen;
    int                     cycles      = 0;
    int                     stall_left  = 0;
    int                     stall_pct   = 0;
    bit                     quiet_tail  = 1'b0;
    int                     idle_pct    = 0;
    int                     beats_sent  = 0;
    int                     frames_sent = 0;
    logic [LABEL_W-1:0]     cur_nodata  = NO_DATA_RESET;

    always #2 aclk = ~aclk;

    label_bounding_box_table #(
        .LABELS   (LABELS),
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    label_bounding_box_table_checker #(
        .LABELS   (LABELS),
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .mismatches   (mismatches),
        .results_due  (results_due),
        .results_seen (results_seen)
    );

    // result-side back-pressure: random stalls of m_tready
    always @(posedge aclk) begin
        if (!aresetn || quiet_tail) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, results_due);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_req(input logic [1:0] req, input logic [LABEL_W-1:0] lab);
        int gap;
        if (!quiet_tail && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= lab;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
        if (req == REQ_FRAME) frames_sent++;
    endtask

    // every result in, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [LABEL_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_config(input logic [LABEL_W-1:0] cols, input logic [LABEL_W-1:0] nd);
        drain();
        write_reg(CFG_RASTER_COLS, cols);
        write_reg(CFG_NO_DATA, nd);
        cfg_valid  <= 1'b0;
        cur_nodata = nd;
    endtask

    function automatic logic [LABEL_W-1:0] pick_label();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return LABEL_W'($urandom_range(0, LABEL_POOL - 1));
        if (r < 70) return cur_nodata;
        if (r < 76) return LABEL_W'($urandom_range(LABELS - 2, LABELS - 1));
        if (r < 83) return LABEL_W'($urandom_range(0, 16'hFFFF));
        if (r < 88) return LABEL_W'($urandom_range(LABELS, 16'h7FFF));
        if (r < 93) return LABEL_W'($urandom_range(16'h8000, 16'hFFFF));
        return LABEL_W'($urandom_range(0, LABELS - 1));
    endfunction

    task automatic random_req();
        int r;
        r = $urandom_range(0, 99);
        if (r < 76)      send_req(REQ_PIXEL, pick_label());
        else if (r < 94) send_req(REQ_READ, pick_label());
        else if (r < 97) send_req(REQ_FRAME, LABEL_W'($urandom_range(0, 16'hFFFF)));
        else             send_req(REQ_UNUSED, LABEL_W'($urandom_range(0, 16'hFFFF)));
    endtask

    initial begin
        logic [LABEL_W-1:0] lab;
        logic [LABEL_W-1:0] cols;
        logic [LABEL_W-1:0] nd;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset config: 1024 columns, nodata -9999
        send_req(REQ_PIXEL, 16'd0);
        send_req(REQ_PIXEL, 16'd1023);
        send_req(REQ_PIXEL, 16'd1024);
        send_req(REQ_PIXEL, 16'hFFFF);
        send_req(REQ_PIXEL, 16'h8000);
        send_req(REQ_PIXEL, 16'h7FFF);
        send_req(REQ_PIXEL, NO_DATA_RESET);
        send_req(REQ_PIXEL, 16'd0);
        send_req(REQ_UNUSED, 16'hFFFF);
        send_req(REQ_READ, 16'd0);
        send_req(REQ_READ, 16'd1023);
        send_req(REQ_READ, 16'd5);
        send_req(REQ_READ, 16'hFFFF);
        send_req(REQ_READ, 16'd1024);
        send_req(REQ_READ, 16'h8000);
        send_req(REQ_READ, 16'h7FFF);
        send_req(REQ_FRAME, 16'd0);
        send_req(REQ_READ, 16'd0);
        send_req(REQ_PIXEL, 16'd7);
        send_req(REQ_READ, 16'd7);

        // zero width clamps to one column, so every pixel is a row of its own;
        // the positive-extreme nodata label fills the gaps
        set_config(16'd0, 16'h7FFF);
        idle_pct  = 10;
        stall_pct <= 10;
        send_req(REQ_FRAME, 16'd0);
        for (int i = 0; i < 40; i++) begin
            if (i == 0 || i == 20) lab = 16'd3;
            else if (i >= 30) lab = 16'd4;
            else lab = 16'h7FFF;
            send_req(REQ_PIXEL, lab);
        end
        send_req(REQ_READ, 16'd3);
        send_req(REQ_READ, 16'd4);

        // many short frames, enough to roll the frame tags over
        set_config(16'd3, 16'd2);
        idle_pct  = 20;
        stall_pct <= 20;
        for (int i = 0; i < 260; i++) begin
            lab = pick_label();
            send_req(REQ_FRAME, LABEL_W'($urandom_range(0, 16'hFFFF)));
            send_req(REQ_PIXEL, lab);
            if (i % 4 == 0) send_req(REQ_READ, lab);
            else if (i % 4 == 2) send_req(REQ_READ, LABEL_W'($urandom_range(0, LABEL_POOL - 1)));
        end

        for (int p = 0; p < 9; p++) begin
            case (p)
                0:       cols = 16'd1;
                1:       cols = 16'd4096;
                2:       cols = 16'd8191;
                3:       cols = 16'd4095;
                4:       cols = LABEL_W'($urandom_range(0, 16'hFFFF));
                default: cols = LABEL_W'($urandom_range(1, 24));
            endcase
            case ($urandom_range(0, 4))
                0:       nd = NO_DATA_RESET;
                1:       nd = 16'h8000;
                2:       nd = LABEL_W'($urandom_range(0, LABEL_POOL - 1));
                3:       nd = 16'h7FFF;
                default: nd = LABEL_W'($urandom_range(0, 16'hFFFF));
            endcase
            set_config(cols, nd);
            idle_pct  = (p % 3) * 20;
            stall_pct <= ((p + 1) % 3) * 15;
            if (p == 8) quiet_tail <= 1'b1;
            send_req(REQ_FRAME, 16'd0);
            for (int i = 0; i < 90; i++) random_req();
        end

        drain();
        $display("checked %0d result beats from %0d request beats (%0d new frames)",
                 results_seen, beats_sent, frames_sent);
        $display("covered clamped row widths, frame tag rollover and several nodata labels");
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/lbt_pkg.sv
rtl/lbt_entry_ram.sv
rtl/lbt_update.sv
rtl/lbt_position.sv
rtl/label_bounding_box_table.sv
tb/label_bounding_box_table_checker.sv
tb/label_bounding_box_table_tb.sv
